// ===== sv/p3d_pkg.sv =====
package p3d_pkg;

  // APB address width: eight 32-bit registers
  localparam int ADDR_W = 5;

  // Serial divider widths
  localparam int DVD_W  = 31;  // dividend (numerator plus depth) and quotient
  localparam int DSR_W  = 22;  // divisor, twice the depth
  localparam int NEAR_W = 22;  // signed camera-space depth

  // Register map, word index
  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH      = 3'd0,
    REG_SCREEN_HEIGHT     = 3'd1,
    REG_CAMERA_HEIGHT     = 3'd2,
    REG_CAMERA_Z          = 3'd3,
    REG_VIEW_DIST         = 3'd4,
    REG_LANE_SPAN         = 3'd5,
    REG_SEG_LEN           = 3'd6,
    REG_ROAD_START_OFFSET = 3'd7
  } p3d_reg_e;

  // Quad order within one segment
  typedef enum logic [1:0] {
    KIND_GRASS = 2'd0,
    KIND_LEFT  = 2'd1,
    KIND_RIGHT = 2'd2,
    KIND_ROAD  = 2'd3
  } p3d_kind_e;

  typedef struct packed {
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    logic [9:0]  camera_height;
    logic [9:0]  camera_z;
    logic [7:0]  view_dist;
    logic [9:0]  lane_span;
    logic [7:0]  seg_len;
    logic [15:0] road_start_offset;
  } p3d_cfg_t;

  // Quotients of one segment handed to the quad formatter
  typedef struct packed {
    logic [DVD_W-1:0] wt;
    logic [DVD_W-1:0] wb;
    logic [DVD_W-1:0] yt;
    logic [DVD_W-1:0] yb;
    logic [11:0]      screen_width;
    logic [11:0]      screen_height;
    logic             phase;
  } p3d_edges_t;

  // Reset values of the registers
  localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd640;
  localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd480;
  localparam logic [9:0]  RST_CAMERA_HEIGHT = 10'd25;
  localparam logic [9:0]  RST_CAMERA_Z      = 10'd1;
  localparam logic [7:0]  RST_VIEW_DIST     = 8'd7;
  localparam logic [9:0]  RST_LANE_SPAN     = 10'd40;
  localparam logic [7:0]  RST_SEG_LEN       = 8'd30;
  localparam logic [15:0] RST_ROAD_START    = 16'd0;

  // Shades
  localparam logic [7:0] SHADE_GRASS_ON  = 8'd128;
  localparam logic [7:0] SHADE_GRASS_OFF = 8'd160;
  localparam logic [7:0] SHADE_BORDER_ON  = 8'd96;
  localparam logic [7:0] SHADE_BORDER_OFF = 8'd224;
  localparam logic [7:0] SHADE_ROAD      = 8'd32;

  // x/3 = (x*171)>>9 exactly for 8-bit x
  localparam logic [15:0] RECIP3  = 16'd171;
  // x/10 = (x*0xCCCD)>>19 exactly for 16-bit x
  localparam logic [31:0] RECIP10 = 32'd52429;

  // Index is a multiple of three
  function automatic logic is_mult3(input logic [7:0] x);
    logic [15:0] p;
    logic [7:0]  q3;
    p  = 16'(x) * RECIP3;
    q3 = 8'(p[15:9]) * 8'd3;
    return x == q3;
  endfunction

endpackage

// ===== sv/p3d_seg_if.sv =====
interface p3d_seg_if;
  logic       valid;
  logic       ready;
  logic [7:0] segment_index;
  logic [3:0] road_block;

  modport source (output valid, segment_index, road_block, input ready);
  modport sink   (input valid, segment_index, road_block, output ready);
endinterface

// ===== sv/p3d_quad_if.sv =====
interface p3d_quad_if;
  logic               valid;
  logic               ready;
  logic [1:0]         quad_kind;
  logic [7:0]         shade;
  logic signed [15:0] x_top_left;
  logic signed [15:0] x_top_right;
  logic signed [15:0] x_bottom_right;
  logic signed [15:0] x_bottom_left;
  logic signed [15:0] y_top;
  logic signed [15:0] y_bottom;
  logic               last;

  modport source (output valid, quad_kind, shade, x_top_left, x_top_right, x_bottom_right,
                  x_bottom_left, y_top, y_bottom, last, input ready);
  modport sink   (input valid, quad_kind, shade, x_top_left, x_top_right, x_bottom_right,
                  x_bottom_left, y_top, y_bottom, last, output ready);
endinterface

// ===== sv/p3d_div.sv =====
// Restoring divider, one quotient bit per step, MSB first
module p3d_div (
  input  logic                      clk,
  input  logic                      start,
  input  logic                      step,
  input  logic [p3d_pkg::DVD_W-1:0] dividend,
  input  logic [p3d_pkg::DSR_W-1:0] divisor,
  output logic [p3d_pkg::DVD_W-1:0] quotient
);

  logic [p3d_pkg::DSR_W-1:0] rem;
  logic [p3d_pkg::DSR_W-1:0] dsr;
  logic [p3d_pkg::DVD_W-1:0] quo;
  logic [p3d_pkg::DSR_W:0]   trial;
  logic                      take;

  // shift next dividend bit into the partial remainder and try a subtract
  assign trial = {rem, quo[p3d_pkg::DVD_W-1]};
  assign take  = trial >= {1'b0, dsr};

  // quo holds the remaining dividend bits on the left, quotient bits on the right
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (step) begin
      rem <= take ? p3d_pkg::DSR_W'(trial - {1'b0, dsr}) : trial[p3d_pkg::DSR_W-1:0];
      quo <= {quo[p3d_pkg::DVD_W-2:0], take};
    end
  end

  assign quotient = quo;

endmodule

// ===== sv/p3d_apb.sv =====
// Configuration registers behind an APB slave
module p3d_apb (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [p3d_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output p3d_pkg::p3d_cfg_t          cfg
);

  p3d_pkg::p3d_reg_e sel;

  assign sel    = p3d_pkg::p3d_reg_e'(paddr[p3d_pkg::ADDR_W-1:2]);
  assign pready = 1'b1;

  // register writes in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width      <= p3d_pkg::RST_SCREEN_WIDTH;
      cfg.screen_height     <= p3d_pkg::RST_SCREEN_HEIGHT;
      cfg.camera_height     <= p3d_pkg::RST_CAMERA_HEIGHT;
      cfg.camera_z          <= p3d_pkg::RST_CAMERA_Z;
      cfg.view_dist         <= p3d_pkg::RST_VIEW_DIST;
      cfg.lane_span         <= p3d_pkg::RST_LANE_SPAN;
      cfg.seg_len           <= p3d_pkg::RST_SEG_LEN;
      cfg.road_start_offset <= p3d_pkg::RST_ROAD_START;
    end else if (psel && penable && pwrite) begin
      unique case (sel)
        p3d_pkg::REG_SCREEN_WIDTH:      cfg.screen_width      <= pwdata[11:0];
        p3d_pkg::REG_SCREEN_HEIGHT:     cfg.screen_height     <= pwdata[11:0];
        p3d_pkg::REG_CAMERA_HEIGHT:     cfg.camera_height     <= pwdata[9:0];
        p3d_pkg::REG_CAMERA_Z:          cfg.camera_z          <= pwdata[9:0];
        p3d_pkg::REG_VIEW_DIST:         cfg.view_dist         <= pwdata[7:0];
        p3d_pkg::REG_LANE_SPAN:         cfg.lane_span         <= pwdata[9:0];
        p3d_pkg::REG_SEG_LEN:           cfg.seg_len           <= pwdata[7:0];
        p3d_pkg::REG_ROAD_START_OFFSET: cfg.road_start_offset <= pwdata[15:0];
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (sel)
      p3d_pkg::REG_SCREEN_WIDTH:      prdata = 32'(cfg.screen_width);
      p3d_pkg::REG_SCREEN_HEIGHT:     prdata = 32'(cfg.screen_height);
      p3d_pkg::REG_CAMERA_HEIGHT:     prdata = 32'(cfg.camera_height);
      p3d_pkg::REG_CAMERA_Z:          prdata = 32'(cfg.camera_z);
      p3d_pkg::REG_VIEW_DIST:         prdata = 32'(cfg.view_dist);
      p3d_pkg::REG_LANE_SPAN:         prdata = 32'(cfg.lane_span);
      p3d_pkg::REG_SEG_LEN:           prdata = 32'(cfg.seg_len);
      p3d_pkg::REG_ROAD_START_OFFSET: prdata = 32'(cfg.road_start_offset);
    endcase
  end

endmodule

// ===== sv/p3d_quad.sv =====
// Turns the four quotients of a segment into four quads and hands them out
module p3d_quad (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  p3d_pkg::p3d_edges_t edges,
  output logic                busy,
  p3d_quad_if.source          quad
);

  // clamp an unsigned quotient to 16 bits; anything larger saturates later anyway
  function automatic logic [15:0] clamp16u(input logic [p3d_pkg::DVD_W-1:0] v);
    return (v > p3d_pkg::DVD_W'(16'hFFFF)) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767)       return 16'h7FFF;
    else if (v < -19'sd32768) return 16'h8000;
    else                      return v[15:0];
  endfunction

  function automatic logic [15:0] row_sat(input logic [11:0] h,
                                          input logic [p3d_pkg::DVD_W-1:0] q);
    logic [16:0] s;
    s = 17'(h[11:1]) + 17'(clamp16u(q));
    return (s > 17'd32767) ? 16'h7FFF : s[15:0];
  endfunction

  function automatic logic [12:0] div10(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * p3d_pkg::RECIP10;
    return p[31:19];
  endfunction

  logic              v1, v2, emit;
  p3d_pkg::p3d_kind_e kind;
  logic [15:0]       ht, hb;
  logic [12:0]       dt, db;
  logic [10:0]       ctr;
  logic [11:0]       wid;
  logic [15:0]       yt_s, yb_s;
  logic [7:0]        grass_sh, border_sh;
  logic [15:0]       lt_in, lt_out, lb_out, lb_in;
  logic [15:0]       rt_in, rt_out, rb_out, rb_in;
  logic signed [18:0] cs, hts, hbs, dts, dbs;

  assign cs  = 19'(ctr);
  assign hts = 19'(ht);
  assign hbs = 19'(hb);
  assign dts = 19'(dt);
  assign dbs = 19'(db);

  // stage 1 halves and rows, stage 2 the twentieths, stage 3 the corners
  always_ff @(posedge clk) begin
    if (load) begin
      ht        <= clamp16u({1'b0, edges.wt[p3d_pkg::DVD_W-1:1]});
      hb        <= clamp16u({1'b0, edges.wb[p3d_pkg::DVD_W-1:1]});
      ctr       <= edges.screen_width[11:1];
      wid       <= edges.screen_width;
      yt_s      <= row_sat(edges.screen_height, edges.yt);
      yb_s      <= row_sat(edges.screen_height, edges.yb);
      grass_sh  <= edges.phase ? p3d_pkg::SHADE_GRASS_ON  : p3d_pkg::SHADE_GRASS_OFF;
      border_sh <= edges.phase ? p3d_pkg::SHADE_BORDER_ON : p3d_pkg::SHADE_BORDER_OFF;
    end
    if (v1) begin
      dt <= div10(ht);
      db <= div10(hb);
    end
    if (v2) begin
      lt_in  <= sat16(cs - hts);
      lt_out <= sat16(cs - hts - dts);
      lb_out <= sat16(cs - hbs - dbs);
      lb_in  <= sat16(cs - hbs);
      rt_in  <= sat16(cs + hts);
      rt_out <= sat16(cs + hts + dts);
      rb_out <= sat16(cs + hbs + dbs);
      rb_in  <= sat16(cs + hbs);
    end
  end

  // control: pipeline flags and the quad counter
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      emit <= 1'b0;
      kind <= p3d_pkg::KIND_GRASS;
    end else begin
      v1 <= load;
      v2 <= v1;
      if (v2) begin
        emit <= 1'b1;
        kind <= p3d_pkg::KIND_GRASS;
      end else if (quad.valid && quad.ready) begin
        if (kind == p3d_pkg::KIND_ROAD) emit <= 1'b0;
        else kind <= p3d_pkg::p3d_kind_e'(kind + 2'd1);
      end
    end
  end

  assign busy = v1 || v2 || emit;

  // word out
  assign quad.valid     = emit;
  assign quad.quad_kind = kind;
  assign quad.y_top     = yt_s;
  assign quad.y_bottom  = yb_s;
  assign quad.last      = kind == p3d_pkg::KIND_ROAD;

  always_comb begin
    unique case (kind)
      p3d_pkg::KIND_GRASS: begin
        quad.shade          = grass_sh;
        quad.x_top_left     = '0;
        quad.x_top_right    = 16'(wid);
        quad.x_bottom_right = 16'(wid);
        quad.x_bottom_left  = '0;
      end
      p3d_pkg::KIND_LEFT: begin
        quad.shade          = border_sh;
        quad.x_top_left     = lt_in;
        quad.x_top_right    = lt_out;
        quad.x_bottom_right = lb_out;
        quad.x_bottom_left  = lb_in;
      end
      p3d_pkg::KIND_RIGHT: begin
        quad.shade          = border_sh;
        quad.x_top_left     = rt_in;
        quad.x_top_right    = rt_out;
        quad.x_bottom_right = rb_out;
        quad.x_bottom_left  = rb_in;
      end
      p3d_pkg::KIND_ROAD: begin
        quad.shade          = p3d_pkg::SHADE_ROAD;
        quad.x_top_left     = lt_in;
        quad.x_top_right    = rt_in;
        quad.x_bottom_right = rb_in;
        quad.x_bottom_left  = lb_in;
      end
    endcase
  end

endmodule

// ===== sv/pseudo3d_road_segment_projector_unit.sv =====
// Flow: after the remainder, multiply and sum states, a segment behind the camera returns
// to idle at the depth check; any other runs two 31-step bit-serial divisions (near, then
// far), width and row quotients side by side, and its quads leave one word a cycle while
// the sink takes them. A new segment is taken once the last one is in the quad formatter.
// Reset: synchronous, clears the sequencer, the rumble phase and the output pipeline and
// loads the register defaults; no clearing pass.
module pseudo3d_road_segment_projector_unit #(
  parameter int SEGMENTS_PER_BLOCK = 150
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [p3d_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  p3d_seg_if.sink                    segment,
  p3d_quad_if.source                 quad
);

  localparam logic [8:0] SPB      = 9'(SEGMENTS_PER_BLOCK);
  localparam logic [4:0] MOD_LAST = 5'd7;
  localparam logic [4:0] DIV_LAST = 5'(p3d_pkg::DVD_W - 1);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MOD  = 9'b000000010,
    ST_MUL  = 9'b000000100,
    ST_SUM  = 9'b000001000,
    ST_CHK  = 9'b000010000,
    ST_DIVN = 9'b000100000,
    ST_NXT  = 9'b001000000,
    ST_DIVF = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  p3d_pkg::p3d_cfg_t   cfg;
  p3d_pkg::p3d_edges_t edges;

  state_t      state;
  logic [4:0]  cnt;
  logic        phase;
  logic [7:0]  idx_sh;
  logic [8:0]  seg_rem;
  logic [3:0]  blk;
  logic [12:0] bs;
  logic [17:0] p1, q1;
  logic [20:0] nb;
  logic [15:0] ns;
  logic [29:0] wnum, ynum;
  logic [p3d_pkg::NEAR_W-1:0] near;
  logic [p3d_pkg::NEAR_W-1:0] far;
  logic [p3d_pkg::NEAR_W-1:0] z;
  logic [p3d_pkg::DVD_W-1:0]  wb_q, yb_q, quo_w, quo_y;
  logic [p3d_pkg::DVD_W-1:0]  dvd_w, dvd_y;
  logic [p3d_pkg::DSR_W-1:0]  dsr;
  logic [8:0]  mod_trial;
  logic        mod_take;
  logic        near_pos;
  logic        d_start, d_step;
  logic        q_load, q_busy;

  p3d_apb u_apb (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // serial remainder of the index by the block length
  assign mod_trial = {seg_rem[7:0], idx_sh[7]};
  assign mod_take  = mod_trial >= SPB;

  // depth and divider operands
  assign near_pos = !near[p3d_pkg::NEAR_W-1] && (near != '0);
  assign far      = near + p3d_pkg::NEAR_W'(cfg.seg_len);
  assign z        = (state == ST_NXT) ? far : near;
  assign dvd_w    = p3d_pkg::DVD_W'(wnum) + p3d_pkg::DVD_W'(z);
  assign dvd_y    = p3d_pkg::DVD_W'(ynum) + p3d_pkg::DVD_W'(z);
  assign dsr      = {z[p3d_pkg::DSR_W-2:0], 1'b0};
  assign d_start  = (state == ST_CHK) || (state == ST_NXT);
  assign d_step   = (state == ST_DIVN) || (state == ST_DIVF);
  assign q_load   = (state == ST_DONE) && !q_busy;

  // width lane and row lane share the step count
  p3d_div u_div_w (
    .clk, .start(d_start), .step(d_step), .dividend(dvd_w), .divisor(dsr), .quotient(quo_w)
  );
  p3d_div u_div_y (
    .clk, .start(d_start), .step(d_step), .dividend(dvd_y), .divisor(dsr), .quotient(quo_y)
  );

  assign segment.ready = state == ST_IDLE;

  // operand datapath
  always_ff @(posedge clk) begin
    if (segment.valid && segment.ready) begin
      idx_sh  <= segment.segment_index;
      seg_rem <= '0;
      blk     <= segment.road_block;
    end
    if (state == ST_MOD) begin
      seg_rem <= mod_take ? 9'(mod_trial - SPB) : mod_trial;
      idx_sh  <= {idx_sh[6:0], 1'b0};
      bs      <= 13'(blk) * 13'(SPB);
      p1      <= 18'(cfg.view_dist) * 18'(cfg.lane_span);
      q1      <= 18'(cfg.view_dist) * 18'(cfg.camera_height);
    end
    if (state == ST_MUL) begin
      nb   <= 21'(bs) * 21'(cfg.seg_len);
      ns   <= 16'(seg_rem[7:0]) * 16'(cfg.seg_len);
      wnum <= 30'(p1) * 30'(cfg.screen_width);
      ynum <= 30'(q1) * 30'(cfg.screen_height);
    end
    if (state == ST_SUM) begin
      near <= p3d_pkg::NEAR_W'(nb) + p3d_pkg::NEAR_W'(cfg.road_start_offset)
              + p3d_pkg::NEAR_W'(ns) - p3d_pkg::NEAR_W'(cfg.camera_z);
    end
    if (state == ST_NXT) begin
      wb_q <= quo_w;
      yb_q <= quo_y;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      phase <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (segment.valid) begin
            if (p3d_pkg::is_mult3(segment.segment_index)) phase <= ~phase;
            cnt   <= '0;
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          cnt <= cnt + 5'd1;
          if (cnt == MOD_LAST) state <= ST_MUL;
        end
        ST_MUL: state <= ST_SUM;
        ST_SUM: state <= ST_CHK;
        ST_CHK: begin
          cnt   <= '0;
          state <= near_pos ? ST_DIVN : ST_IDLE;
        end
        ST_DIVN: begin
          cnt <= cnt + 5'd1;
          if (cnt == DIV_LAST) state <= ST_NXT;
        end
        ST_NXT: begin
          cnt   <= '0;
          state <= ST_DIVF;
        end
        ST_DIVF: begin
          cnt <= cnt + 5'd1;
          if (cnt == DIV_LAST) state <= ST_DONE;
        end
        ST_DONE: if (!q_busy) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // hand over to the quad formatter: far quotients are still in the dividers
  assign edges.wt            = quo_w;
  assign edges.yt            = quo_y;
  assign edges.wb            = wb_q;
  assign edges.yb            = yb_q;
  assign edges.screen_width  = cfg.screen_width;
  assign edges.screen_height = cfg.screen_height;
  assign edges.phase         = phase;

  p3d_quad u_quad (
    .clk, .rst, .load(q_load), .edges, .busy(q_busy), .quad
  );

  // a segment at or behind the camera produces nothing
  a_skip_nonpos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHK && !near_pos) |=> (state == ST_IDLE))
    else $error("non-positive depth did not return to idle");

  // never overwrite a segment still being emitted
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    q_load |=> !quad.valid)
    else $error("quad load while output busy");

  // the near division runs exactly the full count
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVN && cnt == DIV_LAST) |=> (state == ST_NXT))
    else $error("near division did not end after full count");

  // input held off during the whole computation
  a_busy_hold: assert property (@(posedge clk) disable iff (rst)
    (segment.valid && segment.ready) |=> !segment.ready)
    else $error("second segment taken during computation");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEGS      = 150;
  localparam int LIMIT     = 400000;
  localparam int DRAIN     = 100;  // extra wait once no quad is pending
  localparam int PHASE_LEN = 40;

  localparam logic [7:0] GREY_GRASS_ODD   = 8'd128;
  localparam logic [7:0] GREY_GRASS_EVEN  = 8'd160;
  localparam logic [7:0] GREY_BORDER_ODD  = 8'd96;
  localparam logic [7:0] GREY_BORDER_EVEN = 8'd224;
  localparam logic [7:0] GREY_ROAD        = 8'd32;

  typedef struct packed {
    p3d_pkg::p3d_kind_e kind;
    logic [7:0]         shade;
    logic signed [15:0] xtl;
    logic signed [15:0] xtr;
    logic signed [15:0] xbr;
    logic signed [15:0] xbl;
    logic signed [15:0] yt;
    logic signed [15:0] yb;
    logic               last;
  } quad_word_t;

  typedef enum {RX_OPEN, RX_CHOPPY, RX_SLUGGISH} rx_mode_e;

  // Projection of each accepted segment and the queue of quads still due
  class road_quad_scoreboard;
    p3d_pkg::p3d_cfg_t cfg;
    logic              rumble;
    quad_word_t        expected_quads[$];
    int                errors;

    function new();
      cfg    = '{screen_width: 12'd640, screen_height: 12'd480, camera_height: 10'd25,
                 camera_z: 10'd1, view_dist: 8'd7, lane_span: 10'd40,
                 seg_len: 8'd30, road_start_offset: 16'd0};
      rumble = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return expected_quads.size();
    endfunction

    function logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    // num / (2z), rounding half up
    function longint half_up(longint unsigned num, longint z);
      longint unsigned uz;
      uz = longint'(z);
      return longint'((num + uz) / (2 * uz));
    endfunction

    function void add_quad(p3d_pkg::p3d_kind_e k, logic [7:0] g, longint a, longint b,
                           longint c, longint d, longint yt, longint yb);
      quad_word_t q;
      q.kind  = k;
      q.shade = g;
      q.xtl   = clamp16(a);
      q.xtr   = clamp16(b);
      q.xbr   = clamp16(c);
      q.xbl   = clamp16(d);
      q.yt    = clamp16(yt);
      q.yb    = clamp16(yb);
      q.last  = (k == p3d_pkg::KIND_ROAD);
      expected_quads.insert(expected_quads.size(), q);
    endfunction

    function void note_segment(logic [7:0] idx, logic [3:0] blk);
      longint seg, s, nearz, farz, wt, wb, yt, yb, c, w;
      longint unsigned wnum, ynum;
      logic [7:0] grass, border;
      seg = longint'(idx) % SEGS;
      s   = longint'(cfg.seg_len);
      // phase flips on raw index, even for segments behind the camera
      if (idx % 3 == 0) rumble = ~rumble;
      nearz = longint'(blk) * SEGS * s + longint'(cfg.road_start_offset) + s * seg
              - longint'(cfg.camera_z);
      farz  = nearz + s;
      if (nearz <= 0 || farz <= 0) return;
      wnum = longint'(cfg.view_dist) * longint'(cfg.lane_span)
             * longint'(cfg.screen_width);
      ynum = longint'(cfg.view_dist) * longint'(cfg.camera_height)
             * longint'(cfg.screen_height);
      wt = half_up(wnum, farz);
      wb = half_up(wnum, nearz);
      yt = longint'(cfg.screen_height / 2) + half_up(ynum, farz);
      yb = longint'(cfg.screen_height / 2) + half_up(ynum, nearz);
      c  = longint'(cfg.screen_width / 2);
      w  = longint'(cfg.screen_width);
      grass  = rumble ? GREY_GRASS_ODD : GREY_GRASS_EVEN;
      border = rumble ? GREY_BORDER_ODD : GREY_BORDER_EVEN;
      add_quad(p3d_pkg::KIND_GRASS, grass, 0, w, w, 0, yt, yb);
      add_quad(p3d_pkg::KIND_LEFT, border, c - wt / 2, c - wt / 2 - wt / 20,
               c - wb / 2 - wb / 20, c - wb / 2, yt, yb);
      add_quad(p3d_pkg::KIND_RIGHT, border, c + wt / 2, c + wt / 2 + wt / 20,
               c + wb / 2 + wb / 20, c + wb / 2, yt, yb);
      add_quad(p3d_pkg::KIND_ROAD, GREY_ROAD, c - wt / 2, c + wt / 2, c + wb / 2,
               c - wb / 2, yt, yb);
    endfunction

    function void cmp(string field, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_quad(quad_word_t got);
      quad_word_t exp_q;
      if (expected_quads.size() == 0) begin
        $display("%0t: unexpected quad word, expected none, got kind %0d shade %0d",
                 $time, got.kind, got.shade);
        errors++;
        return;
      end
      exp_q = expected_quads.pop_front();
      cmp("quad_kind", exp_q.kind, got.kind);
      cmp("shade", exp_q.shade, got.shade);
      cmp("x_top_left", exp_q.xtl, got.xtl);
      cmp("x_top_right", exp_q.xtr, got.xtr);
      cmp("x_bottom_right", exp_q.xbr, got.xbr);
      cmp("x_bottom_left", exp_q.xbl, got.xbl);
      cmp("y_top", exp_q.yt, got.yt);
      cmp("y_bottom", exp_q.yb, got.yb);
      cmp("last", exp_q.last, got.last);
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [p3d_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;
  int                         cycles = 0;
  rx_mode_e                   rx_mode = RX_OPEN;
  int                         rx_left = 0;

  road_quad_scoreboard sb = new();

  p3d_seg_if  seg_bus();
  p3d_quad_if quad_bus();

  pseudo3d_road_segment_projector_unit #(
    .SEGMENTS_PER_BLOCK(SEGS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .segment (seg_bus),
    .quad    (quad_bus)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Quad sink: check each word taken, then pick next ready on a drifting pattern
  always @(posedge clk) begin : rx
    quad_word_t got;
    if (rst) begin
      quad_bus.ready <= 1'b0;
    end else begin
      if (quad_bus.valid && quad_bus.ready) begin
        got.kind  = p3d_pkg::p3d_kind_e'(quad_bus.quad_kind);
        got.shade = quad_bus.shade;
        got.xtl   = quad_bus.x_top_left;
        got.xtr   = quad_bus.x_top_right;
        got.xbr   = quad_bus.x_bottom_right;
        got.xbl   = quad_bus.x_bottom_left;
        got.yt    = quad_bus.y_top;
        got.yb    = quad_bus.y_bottom;
        got.last  = quad_bus.last;
        sb.check_quad(got);
      end
      if (rx_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 2));
        rx_left <= $urandom_range(16, 160);
      end else begin
        rx_left <= rx_left - 1;
      end
      unique case (rx_mode)
        RX_OPEN:     quad_bus.ready <= 1'b1;
        RX_CHOPPY:   quad_bus.ready <= 1'($urandom_range(0, 1));
        RX_SLUGGISH: quad_bus.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Hold the segment word until taken; the caller lowers valid
  task automatic send_segment(input logic [7:0] idx, input logic [3:0] blk);
    seg_bus.valid         <= 1'b1;
    seg_bus.segment_index <= idx;
    seg_bus.road_block    <= blk;
    do @(posedge clk); while (!seg_bus.ready);
    sb.note_segment(idx, blk);
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Write all eight registers back to back, only while idle
  task automatic write_config(input p3d_pkg::p3d_cfg_t c);
    p3d_pkg::p3d_reg_e r;
    logic [31:0]       v;
    for (int i = 0; i < 8; i++) begin
      r = p3d_pkg::p3d_reg_e'(i);
      unique case (r)
        p3d_pkg::REG_SCREEN_WIDTH:      v = 32'(c.screen_width);
        p3d_pkg::REG_SCREEN_HEIGHT:     v = 32'(c.screen_height);
        p3d_pkg::REG_CAMERA_HEIGHT:     v = 32'(c.camera_height);
        p3d_pkg::REG_CAMERA_Z:          v = 32'(c.camera_z);
        p3d_pkg::REG_VIEW_DIST:         v = 32'(c.view_dist);
        p3d_pkg::REG_LANE_SPAN:         v = 32'(c.lane_span);
        p3d_pkg::REG_SEG_LEN:           v = 32'(c.seg_len);
        p3d_pkg::REG_ROAD_START_OFFSET: v = 32'(c.road_start_offset);
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {r, 2'b00};
      pwdata  <= v;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.cfg = c;
  endtask

  function automatic int pick(input int lo, input int hi);
    unique case ($urandom_range(0, 5))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic p3d_pkg::p3d_cfg_t random_cfg();
    p3d_pkg::p3d_cfg_t c;
    c.screen_width      = 12'(pick(1, 4095));
    c.screen_height     = 12'(pick(1, 4095));
    c.camera_height     = 10'(pick(0, 1023));
    c.camera_z          = 10'(pick(0, 1023));
    c.view_dist         = 8'(pick(1, 255));
    c.lane_span         = 10'(pick(1, 1023));
    c.seg_len           = 8'(pick(1, 255));
    c.road_start_offset = 16'(pick(0, 65535));
    return c;
  endfunction

  // Bursts of random length; some bursts run straight into the next
  task automatic send_random(input int n);
    int sent, burst, gap;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < n; k++) begin
        send_segment(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        seg_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    seg_bus.valid <= 1'b0;
  endtask

  initial begin
    rst                   <= 1'b1;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    seg_bus.valid         <= 1'b0;
    seg_bus.segment_index <= '0;
    seg_bus.road_block    <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset register values: camera sits just past block start, index past the block
    send_segment(8'd0, 4'd0);
    send_segment(8'd1, 4'd0);
    send_segment(8'd2, 4'd0);
    send_segment(8'd3, 4'd0);
    send_segment(8'd149, 4'd0);
    send_segment(8'd150, 4'd0);
    send_segment(8'd151, 4'd1);
    send_segment(8'd255, 4'd15);
    seg_bus.valid <= 1'b0;
    wait_idle();

    // Sizes at their top, depth of one: saturates both ways
    write_config('{screen_width: 12'd4095, screen_height: 12'd4095, camera_height: 10'd1023,
                   camera_z: 10'd0, view_dist: 8'd255, lane_span: 10'd1023,
                   seg_len: 8'd255, road_start_offset: 16'd1});
    send_segment(8'd0, 4'd0);
    send_segment(8'd255, 4'd15);
    send_segment(8'd3, 4'd5);
    send_segment(8'd0, 4'd15);
    seg_bus.valid <= 1'b0;
    wait_idle();

    // Zero registers: no division by zero, all widths collapse
    write_config('{screen_width: 12'd0, screen_height: 12'd0, camera_height: 10'd0,
                   camera_z: 10'd1023, view_dist: 8'd0, lane_span: 10'd0,
                   seg_len: 8'd0, road_start_offset: 16'd2000});
    send_segment(8'd0, 4'd0);
    send_segment(8'd1, 4'd3);
    send_segment(8'd6, 4'd7);
    seg_bus.valid <= 1'b0;
    wait_idle();

    // Smallest sizes, camera far ahead: near below zero, at zero and above
    write_config('{screen_width: 12'd1, screen_height: 12'd1, camera_height: 10'd1,
                   camera_z: 10'd1023, view_dist: 8'd1, lane_span: 10'd1,
                   seg_len: 8'd1, road_start_offset: 16'd0});
    send_segment(8'd0, 4'd0);
    send_segment(8'd255, 4'd15);
    send_segment(8'd0, 4'd7);
    send_segment(8'd123, 4'd6);
    seg_bus.valid <= 1'b0;
    wait_idle();

    // Random phases; the middle one pauses for a full drain halfway
    for (int p = 0; p < 5; p++) begin
      write_config(random_cfg());
      if (p == 2) begin
        send_random(PHASE_LEN / 2);
        while (sb.pending() != 0) @(posedge clk);
        send_random(PHASE_LEN / 2);
      end else begin
        send_random(PHASE_LEN);
      end
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/p3d_pkg.sv
sv/p3d_seg_if.sv
sv/p3d_quad_if.sv
sv/p3d_div.sv
sv/p3d_apb.sv
sv/p3d_quad.sv
sv/pseudo3d_road_segment_projector_unit.sv
tb/tb_top.sv
